// File: src/deq_pkg.sv
// Shared types and constants of the double-ended queue.
package deq_pkg;

	localparam int FUNC_W   = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 6;

	// Operation codes carried in the func field.
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_DUMP       = 3'd4
	} func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Request from the sequencer to load the result register.
	typedef struct packed {
		logic    load;
		logic    from_mem;
		status_t status;
		logic    last;
	} emit_t;

endpackage

// File: src/deq_if.sv
// Request and result channel interfaces of the double-ended queue.
interface deq_req_if;
	import deq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink (input valid, input func, input push_value, output ready);
endinterface

interface deq_rsp_if;
	import deq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	logic [STATUS_W-1:0]      status;
	logic [OCC_W-1:0]         occupancy;
	logic                     last;

	modport source (output valid, output data_out, output status, output occupancy,
		output last, input ready);
	modport sink (input valid, input data_out, input status, input occupancy,
		input last, output ready);
endinterface

// File: src/double_ended_queue_core.sv
// Top level of the double-ended queue: store, sequencer and result register.
// Pushes and ignored codes: result valid the next cycle; one per cycle while rsp.ready holds.
// Pops: the word passes through the store's registered read port, then the result register.
// Dump of N words: read port, then result register; one word per cycle while rsp.ready holds.
// Reset clears the head, the count and the control state; the store keeps its contents.
module double_ended_queue_core #(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	emit_t                    emit;
	logic [OCC_W-1:0]         occ_next;
	logic                     out_free;
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                     mem_re;
	logic [AW-1:0]            mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] data_q;
	logic [STATUS_W-1:0]      status_q;
	logic [OCC_W-1:0]         occ_q;
	logic                     last_q;

	deq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	deq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.func       (req.func),
		.push_value (req.push_value),
		.req_ready  (req.ready),
		.out_free   (out_free),
		.emit       (emit),
		.occupancy  (occ_next),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr)
	);

	// The result register can take a new result when empty or being drained.
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= emit.load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_free && emit.load) begin
			data_q   <= emit.from_mem ? mem_rdata : '0;
			status_q <= emit.status;
			occ_q    <= occ_next;
			last_q   <= emit.last;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data_out  = data_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_q;
	assign rsp.last      = last_q;

	// A new request is only taken when its result has a place to go.
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> out_free)
		else $error("request accepted while the result register is blocked");

	// The reported occupancy never exceeds the depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ({1'b0, occ_q} <= 7'(DEPTH)))
		else $error("occupancy beyond depth");

	// Error results carry zero data and close their transaction.
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != ST_OK)) |-> ((data_q == '0) && last_q))
		else $error("error result with data or without last");

endmodule

// File: src/deq_mem.sv
// Word store: one write port and one read port with registered read data.
module deq_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [deq_pkg::DATA_W-1:0] wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic signed [deq_pkg::DATA_W-1:0] rdata
);
	import deq_pkg::*;

	logic signed [DATA_W-1:0] store_q [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/deq_ctrl.sv
// Sequencer: head index, occupancy count, store addressing and result requests.
module deq_ctrl #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int CW    = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [deq_pkg::FUNC_W-1:0]        func,
	input  logic signed [deq_pkg::DATA_W-1:0] push_value,
	output logic                              req_ready,
	input  logic                              out_free,
	output deq_pkg::emit_t                    emit,
	output logic [deq_pkg::OCC_W-1:0]         occupancy,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr,
	output logic signed [deq_pkg::DATA_W-1:0] mem_wdata,
	output logic                              mem_re,
	output logic [AW-1:0]                     mem_raddr
);
	import deq_pkg::*;

	localparam int SW = AW + 1;

	typedef enum logic {
		S_IDLE,
		S_STREAM
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] left_q, left_d;
	logic          accept;
	logic          full;
	logic          empty;

	// Reduces a sum below twice the depth into the index range.
	function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
		return r[AW-1:0];
	endfunction

	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign occupancy = OCC_W'(count_d);
	assign mem_wdata = push_value;

	// Next-state logic: pushes finish at acceptance, reads stream out of the store.
	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		count_d       = count_q;
		ptr_d         = ptr_q;
		left_d        = left_q;
		emit.load     = 1'b0;
		emit.from_mem = 1'b0;
		emit.status   = ST_OK;
		emit.last     = 1'b1;
		mem_we        = 1'b0;
		mem_waddr     = head_q;
		mem_re        = 1'b0;
		mem_raddr     = head_q;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FN_PUSH_FRONT: begin
							emit.load = 1'b1;
							if (full) begin
								emit.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = (head_q == '0) ? AW'(DEPTH - 1) : (head_q - AW'(1));
								head_d    = mem_waddr;
								count_d   = count_q + CW'(1);
							end
						end
						FN_PUSH_BACK: begin
							emit.load = 1'b1;
							if (full) begin
								emit.status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = wrap_sum({1'b0, head_q} + SW'(count_q));
								count_d   = count_q + CW'(1);
							end
						end
						FN_POP_FRONT: begin
							if (empty) begin
								emit.load   = 1'b1;
								emit.status = ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								head_d  = wrap_sum({1'b0, head_q} + SW'(1));
								count_d = count_q - CW'(1);
								left_d  = CW'(1);
								state_d = S_STREAM;
							end
						end
						FN_POP_BACK: begin
							if (empty) begin
								emit.load   = 1'b1;
								emit.status = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = wrap_sum({1'b0, head_q} + SW'(count_q - CW'(1)));
								count_d   = count_q - CW'(1);
								left_d    = CW'(1);
								state_d   = S_STREAM;
							end
						end
						FN_DUMP: begin
							if (empty) begin
								emit.load   = 1'b1;
								emit.status = ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								ptr_d   = wrap_sum({1'b0, head_q} + SW'(1));
								left_d  = count_q;
								state_d = S_STREAM;
							end
						end
						default: begin
							// Undefined operations report the occupancy and change nothing.
							emit.load = 1'b1;
						end
					endcase
				end
			end
			S_STREAM: begin
				if (out_free) begin
					emit.load     = 1'b1;
					emit.from_mem = 1'b1;
					emit.last     = (left_q == CW'(1));
					left_d        = left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_d = S_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ptr_q;
						ptr_d     = wrap_sum({1'b0, ptr_q} + SW'(1));
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			ptr_q   <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			left_q  <= left_d;
		end
	end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the double-ended queue core.
`timescale 1ns / 1ps

module testbench;
	import deq_pkg::*;

	localparam int DEPTH = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;

	// Codes five to seven carry no operation; the block answers them with a plain result.
	localparam logic [FUNC_W-1:0] FN_RESERVED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RESERVED_HI = 3'd7;

	// Idle phases: sender idles lightly, then heavily, then never.
	localparam int unsigned PHASE_SINK_SLOW = 0;
	localparam int unsigned PHASE_SOURCE_SLOW = 1;
	localparam int unsigned PHASE_NO_IDLE = 2;

	typedef struct {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value;
		bit                       drain;
		int unsigned              next_phase;
	} deque_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
		logic                     last;
	} deque_result_t;

	logic clk;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	deque_op_t     pending_ops[$];
	deque_result_t expected_results[$];

	// Predicted contents of the queue.
	logic signed [DATA_W-1:0] deque_words[DEPTH];
	int unsigned              deque_head = 0;
	int unsigned              deque_count = 0;

	int unsigned idle_phase = PHASE_SINK_SLOW;
	bit          draining = 1'b0;
	bit          req_taken = 1'b0;
	int          quiet_cycles = 0;
	int          mismatches = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Appends one expected result with the occupancy that follows the operation.
	task automatic post_result(input logic signed [DATA_W-1:0] data, input status_t status,
		input logic last);
		deque_result_t res;
		res.data = data;
		res.status = status;
		res.occupancy = OCC_W'(deque_count);
		res.last = last;
		expected_results.push_back(res);
	endtask

	// Applies one accepted transaction to the predicted queue and records its results.
	task automatic model_deque(input logic [FUNC_W-1:0] fn,
		input logic signed [DATA_W-1:0] val);
		int unsigned slot;
		logic signed [DATA_W-1:0] word;
		case (fn)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (deque_count >= DEPTH) begin
					post_result('0, ST_FULL, 1'b1);
				end else begin
					if (fn == FN_PUSH_FRONT) begin
						deque_head = (deque_head + DEPTH - 1) % DEPTH;
						deque_words[deque_head] = val;
					end else begin
						deque_words[(deque_head + deque_count) % DEPTH] = val;
					end
					deque_count++;
					post_result('0, ST_OK, 1'b1);
				end
			end
			FN_POP_FRONT, FN_POP_BACK: begin
				if (deque_count == 0) begin
					post_result('0, ST_EMPTY, 1'b1);
				end else begin
					if (fn == FN_POP_FRONT) begin
						word = deque_words[deque_head];
						deque_head = (deque_head + 1) % DEPTH;
					end else begin
						word = deque_words[(deque_head + deque_count - 1) % DEPTH];
					end
					deque_count--;
					post_result(word, ST_OK, 1'b1);
				end
			end
			FN_DUMP: begin
				if (deque_count == 0) begin
					post_result('0, ST_EMPTY, 1'b1);
				end else begin
					for (slot = 0; slot < deque_count; slot++)
						post_result(deque_words[(deque_head + slot) % DEPTH], ST_OK,
							slot + 1 == deque_count);
				end
			end
			default: begin
				post_result('0, ST_OK, 1'b1);
			end
		endcase
	endtask

	// Stimulus building.
	task automatic add_op(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] val);
		deque_op_t op;
		op.func = fn;
		op.value = val;
		op.drain = 1'b0;
		op.next_phase = idle_phase;
		pending_ops.push_back(op);
	endtask

	task automatic add_pause(input int unsigned phase);
		deque_op_t op;
		op.func = FN_PUSH_FRONT;
		op.value = '0;
		op.drain = 1'b1;
		op.next_phase = phase;
		pending_ops.push_back(op);
	endtask

	// Mostly uniform words, with the extremes and zero mixed in.
	function automatic logic signed [DATA_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return '0;
			default: return $urandom();
		endcase
	endfunction

	// Pushes until full, or pops until empty, and then one more of each kind to hit the limit.
	task automatic add_sweep(input bit filling);
		int i;
		logic [FUNC_W-1:0] fn;
		for (i = 0; i < DEPTH + 2; i++) begin
			if (filling)
				fn = (i == DEPTH) ? FN_PUSH_FRONT : (i == DEPTH + 1) ? FN_PUSH_BACK :
					($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK);
			else
				fn = (i == DEPTH) ? FN_POP_FRONT : (i == DEPTH + 1) ? FN_POP_BACK :
					($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK);
			add_op(fn, random_word());
		end
	endtask

	task automatic add_random_ops(input int count);
		int i;
		int unsigned pick;
		logic [FUNC_W-1:0] fn;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 22)
				fn = FN_PUSH_FRONT;
			else if (pick < 44)
				fn = FN_PUSH_BACK;
			else if (pick < 62)
				fn = FN_POP_FRONT;
			else if (pick < 80)
				fn = FN_POP_BACK;
			else if (pick < 92)
				fn = FN_DUMP;
			else
				fn = FUNC_W'($urandom_range(FN_RESERVED_LO, FN_RESERVED_HI));
			add_op(fn, random_word());
		end
	endtask

	// Driver: one request transaction at a time, plus the receiver's ready.
	always @(negedge clk) begin : driver
		deque_op_t op;
		if (arst_n) begin
			if (idle_phase == PHASE_SINK_SLOW)
				rsp_ch.ready <= $urandom_range(0, 99) >= 62;
			else if (idle_phase == PHASE_SOURCE_SLOW)
				rsp_ch.ready <= $urandom_range(0, 99) >= 17;
			else
				rsp_ch.ready <= 1'b1;

			if (req_ch.valid && !req_taken) begin
				// The offered transaction stays on the bus until accepted.
			end else if (draining) begin
				req_ch.valid <= 1'b0;
				if (expected_results.size() == 0)
					draining <= 1'b0;
			end else if (pending_ops.size() != 0 && pending_ops[0].drain) begin
				op = pending_ops.pop_front();
				idle_phase <= op.next_phase;
				draining <= 1'b1;
				req_ch.valid <= 1'b0;
			end else if (pending_ops.size() != 0 &&
				$urandom_range(0, 99) >= (idle_phase == PHASE_SINK_SLOW ? 17 :
				idle_phase == PHASE_SOURCE_SLOW ? 62 : 0)) begin
				op = pending_ops.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.func <= op.func;
				req_ch.push_value <= op.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: checks result transactions, predicts accepted requests, and runs the watchdog.
	always @(posedge clk or negedge arst_n) begin : monitor
		deque_result_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;

			// Results belong to earlier requests, so they are checked before predicting.
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing pending: data_out %0d status %0d",
						rsp_ch.data_out, rsp_ch.status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.data_out !== want.data) begin
						$error("data_out: expected %0d, actual %0d", want.data,
							rsp_ch.data_out);
						mismatches++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d", want.occupancy,
							rsp_ch.occupancy);
						mismatches++;
					end
					if (rsp_ch.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
						mismatches++;
					end
				end
			end

			if (req_ch.valid && req_ch.ready)
				model_deque(req_ch.func, req_ch.push_value);

			// Watchdog on cycles with no transaction on either channel.
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("[double_ended_queue_core] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		req_ch.valid = 1'b0;
		req_ch.func = FN_PUSH_FRONT;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;

		// Empty-queue errors and a code with no operation.
		add_op(FN_POP_FRONT, '0);
		add_op(FN_POP_BACK, '1);
		add_op(FN_DUMP, '0);
		add_op(FN_RESERVED_LO, '1);
		// Extremes at both ends; the front push wraps the head below zero.
		add_op(FN_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
		add_op(FN_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
		add_op(FN_PUSH_FRONT, '1);
		add_op(FN_PUSH_BACK, '0);
		add_op(FN_DUMP, '1);
		add_op(FN_POP_BACK, '0);
		add_op(FN_POP_FRONT, '0);
		add_op(FN_RESERVED_LO + 3'd1, 32'h5555_5555);
		add_op(FN_RESERVED_HI, 32'haaaa_aaaa);
		add_op(FN_POP_FRONT, '0);
		// Popping the only word from the back.
		add_op(FN_POP_BACK, '0);
		add_op(FN_PUSH_FRONT, 32'h5555_5555);
		add_op(FN_POP_BACK, '0);
		add_op(FN_PUSH_BACK, 32'haaaa_aaaa);
		add_op(FN_POP_FRONT, '0);
		add_op(FN_DUMP, '0);

		// Fill to full, dump the whole store, then hold until everything is out.
		add_sweep(1'b1);
		add_op(FN_DUMP, '0);
		add_pause(PHASE_SOURCE_SLOW);
		add_random_ops(8);
		add_sweep(1'b0);
		add_pause(PHASE_NO_IDLE);
		add_random_ops(8);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid || draining ||
			expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[double_ended_queue_core] OK");
		else
			$display("[double_ended_queue_core] ERROR");
		$finish;
	end

endmodule
